### src/hmba_pkg.sv
// Shared constants, codes and control types of the harmonic moment bin accumulator.
package hmba_pkg;

    localparam int NUM_BINS   = 16;
    localparam int MAX_ORDER  = 3;
    localparam int MAX_COEF   = (MAX_ORDER + 1) * (MAX_ORDER + 1);
    localparam int COV_DIM    = 2 * MAX_COEF;
    localparam int IDX_W      = 4;
    localparam int TOT_DEPTH  = 2 * NUM_BINS;
    localparam int TOT_AW     = $clog2(TOT_DEPTH);
    localparam int MOM_DEPTH  = 2 * NUM_BINS * 4 * MAX_COEF;
    localparam int MOM_AW     = $clog2(MOM_DEPTH);
    localparam int COV_DEPTH  = NUM_BINS * COV_DIM * COV_DIM;
    localparam int COV_AW     = $clog2(COV_DEPTH);

    localparam logic [1:0] KIND_NUM  = 2'd0;
    localparam logic [1:0] KIND_DEN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [3:0] RA_DEN_TOT   = 4'd1;
    localparam logic [3:0] RA_FIRST_MOM = 4'd2;
    localparam logic [3:0] RA_LAST_MOM  = 4'd9;
    localparam logic [3:0] RA_COV       = 4'd10;

    typedef enum logic [2:0] {
        CLS_ERR,
        CLS_TOT,
        CLS_MOM,
        CLS_COV,
        CLS_COEF
    } cls_t;

    typedef struct packed {
        logic              clear;
        logic [COV_AW-1:0] clear_addr;
        logic              accept;
        logic              bintot;
        logic              rd;
        logic              mul;
        logic              wr;
        logic              is_cov;
        logic [1:0]        arr;
        logic [IDX_W-1:0]  j;
        logic              dir;
        logic [1:0]        word;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        cls_t             cls;
        logic             side_num;
        logic             k_zero;
        logic [IDX_W-1:0] k;
    } stat_t;

endpackage

### src/harmonic_moment_bin_accumulator.sv
// Top level of the harmonic moment bin accumulator.
//
// Channel   Handshake                 Payload
// input     in_valid / in_stall       kind, bin, coef_index, coef_re, coef_im, weight,
//                                     read_array, read_row, read_col
// output    out_valid / out_stall     read_value, status
// config    cfg_valid / cfg_ready     l_max_in_use
//
// After reset a pass over 16384 addresses clears the memories; no item is taken then.
// A numerator coefficient k updates four moment words and, for each j from 0 to k, four
// covariance words per direction (one direction when j == k); a denominator one updates
// only its four moment words, and coefficient 0 also adds the weight to its bin total.
// Each memory word takes a read, multiply and write-back sequence through one port.
// The next item is taken while a finished result still waits under out_stall.
module harmonic_moment_bin_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [3:0]         bin,
    input  logic [3:0]         coef_index,
    input  logic signed [15:0] coef_re,
    input  logic signed [15:0] coef_im,
    input  logic [15:0]        weight,
    input  logic [3:0]         read_array,
    input  logic [4:0]         read_row,
    input  logic [4:0]         read_col,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] read_value,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         l_max_in_use
);

    hmba_pkg::cmd_t  cmd;
    hmba_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    hmba_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hmba_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .bin        (bin),
        .coef_index (coef_index),
        .coef_re    (coef_re),
        .coef_im    (coef_im),
        .weight     (weight),
        .read_array (read_array),
        .read_row   (read_row),
        .read_col   (read_col),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (l_max_in_use),
        .cmd        (cmd),
        .stat       (stat),
        .read_value (read_value),
        .status     (status)
    );

endmodule

### src/hmba_datapath.sv
// Datapath: item registers, coefficient store, accumulator memories and saturating update.
module hmba_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            kind,
    input  logic [3:0]            bin,
    input  logic [3:0]            coef_index,
    input  logic signed [15:0]    coef_re,
    input  logic signed [15:0]    coef_im,
    input  logic [15:0]           weight,
    input  logic [3:0]            read_array,
    input  logic [4:0]            read_row,
    input  logic [4:0]            read_col,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_data,
    input  hmba_pkg::cmd_t        cmd,
    output hmba_pkg::stat_t       stat,
    output logic signed [63:0]    read_value,
    output logic [1:0]            status
);

    logic [1:0]             lmax_reg;
    logic [3:0]             exp_reg;
    logic [1:0]             kind_reg;
    logic [3:0]             bin_reg;
    logic [3:0]             k_reg;
    logic signed [15:0]     re_reg;
    logic signed [15:0]     im_reg;
    logic [3:0]             ra_reg;
    logic [4:0]             rr_reg;
    logic [4:0]             rc_reg;
    hmba_pkg::cls_t         cls_reg;
    logic signed [32:0]     wre_reg;
    logic signed [32:0]     wim_reg;
    logic [31:0]            w2_reg;
    logic [15:0]            w_reg;
    logic signed [15:0]     pre_reg [hmba_pkg::MAX_COEF];
    logic signed [15:0]     pim_reg [hmba_pkg::MAX_COEF];
    logic signed [63:0]     tot_reg [hmba_pkg::TOT_DEPTH];
    logic [hmba_pkg::COV_AW-1:0] addr_reg;
    logic signed [33:0]     p1_reg;
    logic signed [63:0]     p2_reg;
    logic                   sat_reg;
    logic signed [63:0]     mom_rd_reg;
    logic signed [63:0]     cov_rd_reg;
    logic signed [63:0]     value_reg;
    logic [1:0]             status_reg;
    logic signed [63:0]     mom_mem [hmba_pkg::MOM_DEPTH];
    logic signed [63:0]     cov_mem [hmba_pkg::COV_DEPTH];

    logic [1:0]             lm;
    logic [2:0]             lp1;
    logic [5:0]             n_c;
    hmba_pkg::cls_t         in_cls;
    logic [3:0]             exp_next;
    logic [3:0]             ra_d;
    logic signed [16:0]     cur_a;
    logic signed [16:0]     j_a;
    logic signed [16:0]     ua;
    logic signed [16:0]     ub;
    logic                   ci;
    logic                   cj;
    logic signed [33:0]     covp;
    logic [4:0]             row;
    logic [4:0]             col;
    logic [hmba_pkg::COV_AW-1:0] addr_next;
    logic signed [33:0]     p1_next;
    logic signed [33:0]     mul_b;
    logic signed [67:0]     prod;
    logic signed [63:0]     p1_ext;
    logic signed [63:0]     p2_next;
    logic signed [63:0]     old_val;
    logic signed [63:0]     wr_sum;
    logic                   wr_ovf;
    logic [hmba_pkg::TOT_AW-1:0] tot_idx;
    logic signed [63:0]     tot_sum;
    logic                   tot_ovf;
    logic                   do_write;

    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] d);
        logic signed [64:0] s;
        logic [64:0]        r;
        s = {a[63], a} + {d[63], d};
        if (s[64] != s[63]) begin
            r = {1'b1, s[64], {63{~s[64]}}};
        end else begin
            r = {1'b0, s[63:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        lm  = (lmax_reg > 2'(hmba_pkg::MAX_ORDER)) ? 2'(hmba_pkg::MAX_ORDER) : lmax_reg;
        lp1 = {1'b0, lm} + 3'd1;
        n_c = 6'(lp1) * 6'(lp1);
        in_cls = hmba_pkg::CLS_ERR;
        if ({1'b0, bin} >= 5'(hmba_pkg::NUM_BINS) || kind == hmba_pkg::KIND_BAD) begin
            in_cls = hmba_pkg::CLS_ERR;
        end else if (kind == hmba_pkg::KIND_READ) begin
            if (read_array <= hmba_pkg::RA_DEN_TOT) begin
                in_cls = hmba_pkg::CLS_TOT;
            end else if (read_array <= hmba_pkg::RA_LAST_MOM) begin
                if ({1'b0, read_row} < 6'(hmba_pkg::MAX_COEF)) begin
                    in_cls = hmba_pkg::CLS_MOM;
                end
            end else if (read_array == hmba_pkg::RA_COV) begin
                if ({1'b0, read_row} < 7'(hmba_pkg::COV_DIM)
                    && {1'b0, read_col} < 7'(hmba_pkg::COV_DIM)) begin
                    in_cls = hmba_pkg::CLS_COV;
                end
            end
        end else if ({2'b00, coef_index} < n_c
                     && (coef_index == exp_reg || coef_index == 4'd0)) begin
            in_cls = hmba_pkg::CLS_COEF;
        end
        exp_next = ({2'b00, coef_index} + 6'd1 >= n_c) ? 4'd0 : coef_index + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lmax_reg <= 2'd3;
            exp_reg  <= 4'd0;
        end else begin
            if (cfg_we) begin
                lmax_reg <= cfg_data;
            end
            if (cmd.accept && in_cls == hmba_pkg::CLS_COEF) begin
                exp_reg <= exp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            kind_reg <= kind;
            bin_reg  <= bin;
            k_reg    <= coef_index;
            re_reg   <= coef_re;
            im_reg   <= coef_im;
            w_reg    <= weight;
            ra_reg   <= read_array;
            rr_reg   <= read_row;
            rc_reg   <= read_col;
            cls_reg  <= in_cls;
            wre_reg  <= coef_re * $signed({1'b0, weight});
            wim_reg  <= coef_im * $signed({1'b0, weight});
            w2_reg   <= weight * weight;
            if (in_cls == hmba_pkg::CLS_COEF) begin
                pre_reg[coef_index] <= coef_re;
                pim_reg[coef_index] <= coef_im;
            end
        end
    end

    always_comb
    begin
        ra_d  = ra_reg - hmba_pkg::RA_FIRST_MOM;
        ci    = cmd.dir ? cmd.word[0] : cmd.word[1];
        cj    = cmd.dir ? cmd.word[1] : cmd.word[0];
        cur_a = ci ? -17'(im_reg) : 17'(re_reg);
        j_a   = cj ? -17'(pim_reg[cmd.j]) : 17'(pre_reg[cmd.j]);
        ua    = cur_a;
        ub    = j_a;
        covp  = ua * ub;
        row   = cmd.dir ? {cmd.j, cmd.word[1]} : {k_reg, cmd.word[1]};
        col   = cmd.dir ? {k_reg, cmd.word[0]} : {cmd.j, cmd.word[0]};
        if (cls_reg == hmba_pkg::CLS_MOM) begin
            addr_next = hmba_pkg::COV_AW'({ra_d[2], bin_reg, ra_d[1:0], rr_reg[3:0]});
        end else if (cls_reg == hmba_pkg::CLS_COV) begin
            addr_next = {bin_reg, rr_reg, rc_reg};
        end else if (cmd.is_cov) begin
            addr_next = {bin_reg, row, col};
        end else begin
            addr_next = hmba_pkg::COV_AW'({kind_reg[0], bin_reg, cmd.arr, k_reg});
        end
        if (cmd.is_cov) begin
            p1_next = covp;
        end else if (cmd.arr[0]) begin
            p1_next = 34'(wim_reg);
        end else begin
            p1_next = 34'(wre_reg);
        end
        mul_b  = cmd.is_cov ? $signed({2'b00, w2_reg}) : p1_reg;
        prod   = p1_reg * mul_b;
        p1_ext = 64'(p1_reg);
        if (cmd.is_cov) begin
            p2_next = prod[63:0];
        end else begin
            case (cmd.arr)
                2'd0:    p2_next = p1_ext;
                2'd1:    p2_next = -p1_ext;
                default: p2_next = prod[63:0];
            endcase
        end
        old_val  = cmd.is_cov ? cov_rd_reg : mom_rd_reg;
        {wr_ovf, wr_sum} = sat_add(old_val, p2_reg);
        tot_idx  = {kind_reg[0], bin_reg};
        {tot_ovf, tot_sum} = sat_add(tot_reg[tot_idx], 64'(w_reg));
        do_write = cmd.wr && cls_reg == hmba_pkg::CLS_COEF;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd) begin
            addr_reg <= addr_next;
            p1_reg   <= p1_next;
        end
        if (cmd.mul) begin
            p2_reg <= p2_next;
        end
        if (cmd.accept) begin
            sat_reg <= 1'b0;
        end else if ((do_write && wr_ovf) || (cmd.bintot && tot_ovf)) begin
            sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < hmba_pkg::TOT_DEPTH; i++) begin
                tot_reg[i] <= '0;
            end
        end else if (cmd.bintot) begin
            tot_reg[tot_idx] <= tot_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear) begin
            mom_mem[cmd.clear_addr[hmba_pkg::MOM_AW-1:0]] <= '0;
        end else if (do_write && !cmd.is_cov) begin
            mom_mem[addr_reg[hmba_pkg::MOM_AW-1:0]] <= wr_sum;
        end
        mom_rd_reg <= mom_mem[addr_reg[hmba_pkg::MOM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear) begin
            cov_mem[cmd.clear_addr] <= '0;
        end else if (do_write && cmd.is_cov) begin
            cov_mem[addr_reg] <= wr_sum;
        end
        cov_rd_reg <= cov_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out) begin
            case (cls_reg)
                hmba_pkg::CLS_TOT:
                begin
                    value_reg  <= tot_reg[{ra_reg[0], bin_reg}];
                    status_reg <= hmba_pkg::ST_READ;
                end
                hmba_pkg::CLS_MOM:
                begin
                    value_reg  <= mom_rd_reg;
                    status_reg <= hmba_pkg::ST_READ;
                end
                hmba_pkg::CLS_COV:
                begin
                    value_reg  <= cov_rd_reg;
                    status_reg <= hmba_pkg::ST_READ;
                end
                hmba_pkg::CLS_COEF:
                begin
                    value_reg  <= '0;
                    status_reg <= sat_reg ? hmba_pkg::ST_SAT : hmba_pkg::ST_OK;
                end
                default:
                begin
                    value_reg  <= '0;
                    status_reg <= hmba_pkg::ST_ERR;
                end
            endcase
        end
    end

    assign stat.cls      = cls_reg;
    assign stat.side_num = (kind_reg == hmba_pkg::KIND_NUM);
    assign stat.k_zero   = (k_reg == 4'd0);
    assign stat.k        = k_reg;
    assign read_value    = value_reg;
    assign status        = status_reg;

endmodule

### src/hmba_controller.sv
// Controller: clearing pass, item sequencing and output handshake.
module hmba_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  hmba_pkg::stat_t stat,
    output hmba_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_BINTOT,
        S_RD,
        S_MUL,
        S_WR,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [hmba_pkg::COV_AW-1:0]  clr_reg, clr_next;
    logic [1:0]                   arr_reg, arr_next;
    logic [hmba_pkg::IDX_W-1:0]   j_reg, j_next;
    logic                         dir_reg, dir_next;
    logic [1:0]                   word_reg, word_next;
    logic                         is_cov_reg, is_cov_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         load_out;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        arr_next    = arr_reg;
        j_next      = j_reg;
        dir_next    = dir_reg;
        word_next   = word_reg;
        is_cov_next = is_cov_reg;
        load_out    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == hmba_pkg::COV_AW'(hmba_pkg::COV_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                arr_next  = 2'd0;
                j_next    = '0;
                dir_next  = 1'b0;
                word_next = 2'd0;
                case (stat.cls)
                    hmba_pkg::CLS_COEF:
                    begin
                        is_cov_next = 1'b0;
                        state_next  = stat.k_zero ? S_BINTOT : S_RD;
                    end
                    hmba_pkg::CLS_MOM:
                    begin
                        is_cov_next = 1'b0;
                        state_next  = S_RD;
                    end
                    hmba_pkg::CLS_COV:
                    begin
                        is_cov_next = 1'b1;
                        state_next  = S_RD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_BINTOT: state_next = S_RD;
            S_RD:     state_next = S_MUL;
            S_MUL:    state_next = S_WR;
            S_WR:
            begin
                state_next = S_RD;
                if (stat.cls != hmba_pkg::CLS_COEF) begin
                    state_next = S_DONE;
                end else if (!is_cov_reg) begin
                    if (arr_reg != 2'd3) begin
                        arr_next = arr_reg + 2'd1;
                    end else if (stat.side_num) begin
                        is_cov_next = 1'b1;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (word_reg != 2'd3) begin
                    word_next = word_reg + 2'd1;
                end else begin
                    word_next = 2'd0;
                    if (!dir_reg && j_reg != stat.k) begin
                        dir_next = 1'b1;
                    end else begin
                        dir_next = 1'b0;
                        if (j_reg == stat.k) begin
                            state_next = S_DONE;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            arr_reg       <= '0;
            j_reg         <= '0;
            dir_reg       <= 1'b0;
            word_reg      <= '0;
            is_cov_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            arr_reg       <= arr_next;
            j_reg         <= j_next;
            dir_reg       <= dir_next;
            word_reg      <= word_next;
            is_cov_reg    <= is_cov_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign cmd.clear      = (state_reg == S_CLEAR);
    assign cmd.clear_addr = clr_reg;
    assign cmd.accept     = (state_reg == S_IDLE) && in_valid;
    assign cmd.bintot     = (state_reg == S_BINTOT);
    assign cmd.rd         = (state_reg == S_RD);
    assign cmd.mul        = (state_reg == S_MUL);
    assign cmd.wr         = (state_reg == S_WR);
    assign cmd.is_cov     = is_cov_reg;
    assign cmd.arr        = arr_reg;
    assign cmd.j          = j_reg;
    assign cmd.dir        = dir_reg;
    assign cmd.word       = word_reg;
    assign cmd.load_out   = load_out;

endmodule

### src/hmba_checker.sv
// Port-level checker for the harmonic moment bin accumulator, bound to the top level.
module hmba_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [63:0] read_value,
    input logic [1:0]         status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_value) && $stable(status))
        else $error("Stalled result payload changed.");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != hmba_pkg::ST_READ |-> read_value == 64'sd0)
        else $error("Nonzero value on a result that is not read data.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Second transaction accepted before the first finished.");

endmodule

bind harmonic_moment_bin_accumulator hmba_checker u_hmba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status)
);
